/* hw/rtl/i2cbe_pkg.sv */
// Package for the I2C master bit engine: engine state type, step codes and
// command codes. Used by the step logic and the top level; depends on nothing.
package i2cbe_pkg;

	// Sequencer steps. A step ending in _F is a closing tick.
	typedef enum logic [4:0] {
		S_IDLE = 5'd0,
		S_ST_A = 5'd1,
		S_ST_F = 5'd2,
		S_SP_A = 5'd3,
		S_SP_F = 5'd4,
		S_WR_A = 5'd5,
		S_WR_B = 5'd6,
		S_WR_F = 5'd7,
		S_RD_A = 5'd8,
		S_RD_B = 5'd9,
		S_AK_A = 5'd10,
		S_AK_B = 5'd11,
		S_AK_C = 5'd12,
		S_AK_F = 5'd13,
		S_CK_A = 5'd14,
		S_CK_B = 5'd15,
		S_CK_C = 5'd16,
		S_CK_F = 5'd17
	} step_t;

	// Bus commands.
	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ  = 3'd3,
		OP_CHECK = 3'd4,
		OP_ACK   = 3'd5,
		OP_NACK  = 3'd6
	} op_t;

	localparam logic [2:0]  OP_LAST       = 3'd6;
	localparam logic [15:0] HALF_RESET    = 16'd100;
	localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

	// Complete engine state carried from one tick to the next.
	typedef struct packed {
		step_t       step;
		logic [2:0]  cmd;
		logic [15:0] dly;
		logic [3:0]  bitc;
		logic [7:0]  shreg;
		logic        ack;
		logic        send_ack;
		logic        scl;
		logic        sda;
		logic [7:0]  rd_held;
	} eng_state_t;

	// One tick as seen by the engine.
	typedef struct packed {
		logic       command_valid;
		logic [2:0] operation;
		logic [7:0] write_byte;
		logic       ack_after_read;
		logic       sda_sample;
	} tick_t;

endpackage

/* hw/rtl/i2cbe_in_if.sv */
// Input channel of the I2C master bit engine: one beat per bus tick.
// Plain valid/ready handshake; no package dependency.
interface i2cbe_in_if;
	logic       valid;
	logic       ready;
	logic       command_valid;
	logic [2:0] operation;
	logic [7:0] write_byte;
	logic       ack_after_read;
	logic       sda_sample;

	modport source (output valid, command_valid, operation, write_byte,
		ack_after_read, sda_sample, input ready);
	modport sink (input valid, command_valid, operation, write_byte,
		ack_after_read, sda_sample, output ready);
endinterface

/* hw/rtl/i2cbe_out_if.sv */
// Result channel of the I2C master bit engine: one beat per bus tick.
// Plain valid/ready handshake; no package dependency.
interface i2cbe_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       ack_status;

	modport source (output valid, scl_level, sda_level, busy_res, done_res,
		read_data, ack_status, input ready);
	modport sink (input valid, scl_level, sda_level, busy_res, done_res,
		read_data, ack_status, output ready);
endinterface

/* hw/rtl/i2cbe_step.sv */
// Next-state logic of the I2C master bit engine for one bus tick.
// Depends on i2cbe_pkg for the state struct, step and command codes.
module i2cbe_step (
	input  i2cbe_pkg::eng_state_t cur,
	input  i2cbe_pkg::tick_t      tick,
	input  logic [15:0]           half_ticks,
	output i2cbe_pkg::eng_state_t nxt,
	output logic                  done
);
	import i2cbe_pkg::*;

	logic fin;

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		fin  = 1'b0;

		// Command launch, only from idle.
		if (cur.step == S_IDLE && tick.command_valid && tick.operation <= OP_LAST) begin
			nxt.cmd  = tick.operation;
			nxt.dly  = '0;
			nxt.bitc = '0;
			unique case (op_t'(tick.operation))
				OP_START: nxt.step = S_ST_A;
				OP_STOP:  nxt.step = S_SP_A;
				OP_WRITE: begin
					nxt.shreg = tick.write_byte;
					nxt.step  = S_WR_A;
				end
				OP_READ: begin
					nxt.shreg    = '0;
					nxt.send_ack = tick.ack_after_read;
					nxt.step     = S_RD_A;
				end
				OP_CHECK: nxt.step = S_CK_A;
				OP_ACK: begin
					nxt.send_ack = 1'b1;
					nxt.step     = S_AK_A;
				end
				default: begin
					nxt.send_ack = 1'b0;
					nxt.step     = S_AK_A;
				end
			endcase
		end

		if (nxt.step != S_IDLE) begin
			// Phase start: apply the pin writes on the first tick.
			if (nxt.dly == '0) begin
				unique case (nxt.step)
					S_ST_A: begin
						nxt.sda = 1'b1;
						nxt.scl = 1'b1;
					end
					S_ST_F: begin
						nxt.sda = 1'b0;
						nxt.scl = 1'b0;
						fin     = 1'b1;
					end
					S_SP_A: begin
						nxt.sda = 1'b0;
						nxt.scl = 1'b1;
					end
					S_SP_F: begin
						nxt.sda = 1'b1;
						fin     = 1'b1;
					end
					S_WR_A: begin
						if (nxt.bitc != '0) nxt.scl = 1'b0;
						nxt.sda = nxt.shreg[7];
					end
					S_WR_B: nxt.scl = 1'b1;
					S_WR_F: begin
						nxt.scl = 1'b0;
						nxt.sda = 1'b1;
						fin     = 1'b1;
					end
					S_RD_A: nxt.scl = 1'b1;
					S_RD_B: nxt.scl = 1'b0;
					S_AK_A: nxt.sda = ~nxt.send_ack;
					S_AK_B: nxt.scl = 1'b1;
					S_AK_C: nxt.scl = 1'b0;
					S_AK_F: begin
						if (nxt.send_ack) nxt.sda = 1'b1;
						if (nxt.cmd == OP_READ) nxt.rd_held = nxt.shreg;
						fin = 1'b1;
					end
					S_CK_A: nxt.sda = 1'b1;
					S_CK_B: nxt.scl = 1'b1;
					S_CK_C: nxt.scl = 1'b0;
					default: fin = 1'b1;
				endcase
				if (fin) begin
					done     = 1'b1;
					nxt.step = S_IDLE;
				end else begin
					nxt.dly = (half_ticks != '0) ? half_ticks : 16'd1;
				end
			end

			// Count down the phase and move on at its end.
			if (!fin) begin
				nxt.dly = nxt.dly - 16'd1;
				if (nxt.dly == '0) begin
					unique case (nxt.step)
						S_ST_A: nxt.step = S_ST_F;
						S_SP_A: nxt.step = S_SP_F;
						S_WR_A: nxt.step = S_WR_B;
						S_WR_B: begin
							nxt.shreg = {nxt.shreg[6:0], 1'b0};
							nxt.bitc  = nxt.bitc + 4'd1;
							nxt.step  = (nxt.bitc >= BITS_PER_BYTE) ? S_WR_F : S_WR_A;
						end
						S_RD_A: begin
							nxt.shreg = {nxt.shreg[6:0], tick.sda_sample};
							nxt.step  = S_RD_B;
						end
						S_RD_B: begin
							nxt.bitc = nxt.bitc + 4'd1;
							nxt.step = (nxt.bitc >= BITS_PER_BYTE) ? S_AK_A : S_RD_A;
						end
						S_AK_A: nxt.step = S_AK_B;
						S_AK_B: nxt.step = S_AK_C;
						S_AK_C: nxt.step = S_AK_F;
						S_CK_A: nxt.step = S_CK_B;
						S_CK_B: begin
							nxt.ack  = tick.sda_sample;
							nxt.step = S_CK_C;
						end
						S_CK_C: nxt.step = S_CK_F;
						default: nxt.step = S_IDLE;
					endcase
				end
			end
		end
	end

endmodule

/* hw/rtl/i2c_master_bit_engine_unit.sv */
// I2C master bit engine, top level: input register, step logic, result register.
// Depends on i2cbe_pkg, i2cbe_in_if, i2cbe_out_if and i2cbe_step.
//
// Usage: every beat on the tick channel is one bus tick. It carries the sampled
// SDA level and, when command_valid is high, a command (start, stop, write byte,
// read byte with ACK or NACK, check ACK, send ACK, send NACK). A command offered
// while the engine is busy is dropped; the source watches busy_res and done_res.
// Every tick beat yields exactly one result beat with the SCL/SDA drives, busy,
// the one-beat done pulse, the last read byte and the last ACK sample.
// A tick beat passes the input register, step logic and result register in turn;
// one tick beat is taken in every cycle unless the sink stalls. cfg_we writes the
// half-period length (ticks per bus delay) from cfg_wdata. The user must write it
// only while no command is running; the block does not enforce this. A value
// of zero acts as one. Reset: engine idle, both lines released, half period 100,
// read byte and ACK status zero, both pipeline registers empty.
// When the result sink stalls, the result register holds and the tick register
// fills; ready on the tick channel drops only when both are full.
module i2c_master_bit_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	i2cbe_in_if.sink    tick,
	i2cbe_out_if.source res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import i2cbe_pkg::*;

	logic [15:0] half_ticks_q;
	logic        valid_s1;
	tick_t       tick_s1;
	eng_state_t  eng_q;
	eng_state_t  eng_nxt;
	logic        done_nxt;
	logic        out_valid_q;
	logic        s1_adv;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_ticks_q <= HALF_RESET;
		end else if (cfg_we) begin
			half_ticks_q <= cfg_wdata;
		end
	end

	// Handshake: the stage advances when the result register is free or draining.
	assign s1_adv     = valid_s1 && (!out_valid_q || res.ready);
	assign tick.ready = !valid_s1 || s1_adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.command_valid  <= tick.command_valid;
			tick_s1.operation      <= tick.operation;
			tick_s1.write_byte     <= tick.write_byte;
			tick_s1.ack_after_read <= tick.ack_after_read;
			tick_s1.sda_sample     <= tick.sda_sample;
		end
	end

	i2cbe_step u_step (
		.cur        (eng_q),
		.tick       (tick_s1),
		.half_ticks (half_ticks_q),
		.nxt        (eng_nxt),
		.done       (done_nxt)
	);

	// Engine state, updated once per advanced tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q.step     <= S_IDLE;
			eng_q.cmd      <= '0;
			eng_q.dly      <= '0;
			eng_q.bitc     <= '0;
			eng_q.shreg    <= '0;
			eng_q.ack      <= 1'b0;
			eng_q.send_ack <= 1'b0;
			eng_q.scl      <= 1'b1;
			eng_q.sda      <= 1'b1;
			eng_q.rd_held  <= '0;
		end else if (s1_adv) begin
			eng_q <= eng_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || res.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res.scl_level  <= eng_nxt.scl;
			res.sda_level  <= eng_nxt.sda;
			res.busy_res   <= (eng_nxt.step != S_IDLE);
			res.done_res   <= done_nxt;
			res.read_data  <= eng_nxt.rd_held;
			res.ack_status <= eng_nxt.ack;
		end
	end

	assign res.valid = out_valid_q;

endmodule

/* dv/tb_i2c_master_bit_engine_unit.sv */
// Self-checking testbench for the I2C master bit engine top level.
// Drives bus ticks through the tick interface, checks every result beat against a
// cycle model of the engine. Depends on i2cbe_pkg, i2cbe_in_if, i2cbe_out_if and the top level.
module tb_i2c_master_bit_engine_unit;
	import i2cbe_pkg::*;

	localparam logic [2:0] OP_UNUSED   = 3'd7;
	localparam logic [1:0] SDA_LOW     = 2'd0;
	localparam logic [1:0] SDA_HIGH    = 2'd1;
	localparam logic [1:0] SDA_RAND    = 2'd2;
	localparam int         STALL_LIMIT = 2000;
	localparam int         REPORT_CAP  = 100;

	// One result beat, in port order.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rd;
		logic       ack;
	} bus_beat_t;

	// One directed command: optional half-period write, the command tick, the SDA
	// level held while it runs, and the closing beat where it is obvious.
	typedef struct packed {
		logic        set_half;
		logic [15:0] half;
		logic        cmd_valid;
		logic [2:0]  opcode;
		logic [7:0]  wbyte;
		logic        ackr;
		logic [1:0]  sda_mode;
		logic        intrude;
		logic        has_want;
		bus_beat_t   want;
	} plan_row_t;

	localparam plan_row_t DIR_PLAN [0:17] = '{
		// Idle tick straight out of reset.
		'{1'b0, 16'd0, 1'b0, OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0,
		  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
		// Start at the reset half period, then stop at one tick per delay.
		'{1'b0, 16'd0, 1'b1, OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0,
		  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
		'{1'b1, 16'd1, 1'b1, OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0,
		  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		// Writes of the byte extremes and of A5; SDA is released after the eighth bit.
		'{1'b1, 16'd1, 1'b1, OP_WRITE, 8'hFF, 1'b0, SDA_RAND, 1'b0,
		  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		'{1'b0, 16'd0, 1'b1, OP_WRITE, 8'h00, 1'b1, SDA_RAND, 1'b0,
		  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		'{1'b1, 16'd2, 1'b1, OP_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b0,
		  1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
		// Reads of all ones with ACK and all zeros with NACK.
		'{1'b1, 16'd1, 1'b1, OP_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0,
		  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0}},
		'{1'b0, 16'd0, 1'b1, OP_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0,
		  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		// ACK check seeing NACK, then ACK.
		'{1'b0, 16'd0, 1'b1, OP_CHECK, 8'h00, 1'b0, SDA_HIGH, 1'b0,
		  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
		'{1'b0, 16'd0, 1'b1, OP_CHECK, 8'h00, 1'b0, SDA_LOW, 1'b0,
		  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		// Send ACK and send NACK both end with SDA released.
		'{1'b0, 16'd0, 1'b1, OP_ACK, 8'h00, 1'b0, SDA_RAND, 1'b0,
		  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		'{1'b0, 16'd0, 1'b1, OP_NACK, 8'h00, 1'b1, SDA_RAND, 1'b0,
		  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		// The unused operation code is dropped without a done pulse.
		'{1'b0, 16'd0, 1'b1, OP_UNUSED, 8'h00, 1'b0, SDA_RAND, 1'b0,
		  1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
		// A zero half period behaves as one tick.
		'{1'b1, 16'd0, 1'b1, OP_START, 8'h00, 1'b0, SDA_RAND, 1'b0,
		  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
		'{1'b0, 16'd0, 1'b1, OP_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0,
		  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
		// A command offered while the engine is busy is dropped.
		'{1'b1, 16'd2, 1'b1, OP_WRITE, 8'h5A, 1'b0, SDA_RAND, 1'b1,
		  1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 16'd0, 1'b1, OP_READ, 8'h00, 1'b1, SDA_RAND, 1'b0,
		  1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 16'd0, 1'b1, OP_CHECK, 8'h00, 1'b0, SDA_RAND, 1'b0,
		  1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	i2cbe_in_if  tick_if ();
	i2cbe_out_if res_if ();

	i2c_master_bit_engine_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Engine model state.
	step_t       eng_step;
	logic [2:0]  eng_cmd;
	logic [15:0] dly_cnt;
	logic [3:0]  bit_cnt;
	logic [7:0]  shift_q;
	logic        ack_seen;
	logic        ack_to_send;
	logic        scl_q;
	logic        sda_q;
	logic [7:0]  read_byte;
	logic [15:0] half_ticks;

	bus_beat_t pending_beats [$];
	bus_beat_t last_model_beat;

	int src_idle_pct;
	int snk_idle_pct;
	int mismatch_count = 0;
	int beats_checked  = 0;
	int cmds_run       = 0;
	int done_pulses    = 0;
	int ticks_taken    = 0;
	int stall_cycles   = 0;

	// Clock with a period of 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	function automatic logic pick_sda(logic [1:0] mode);
		if (mode == SDA_HIGH) begin
			return 1'b1;
		end
		if (mode == SDA_LOW) begin
			return 1'b0;
		end
		return rand_bit();
	endfunction

	// A tick with no command and random content in the ignored fields.
	function automatic tick_t idle_tick();
		tick_t t;
		t.command_valid  = 1'b0;
		t.operation      = 3'($urandom_range(7));
		t.write_byte     = 8'($urandom_range(255));
		t.ack_after_read = rand_bit();
		t.sda_sample     = rand_bit();
		return t;
	endfunction

	// Advance the engine model by one tick and return the beat it produces.
	function automatic bus_beat_t advance_engine(tick_t t);
		logic      fin;
		bus_beat_t r;
		fin    = 1'b0;
		r.done = 1'b0;
		// A command starts only on an idle tick.
		if (eng_step == S_IDLE && t.command_valid && t.operation <= OP_LAST) begin
			cmds_run++;
			eng_cmd = t.operation;
			dly_cnt = 16'd0;
			bit_cnt = 4'd0;
			case (t.operation)
				OP_START: eng_step = S_ST_A;
				OP_STOP:  eng_step = S_SP_A;
				OP_WRITE: begin
					shift_q  = t.write_byte;
					eng_step = S_WR_A;
				end
				OP_READ: begin
					shift_q     = 8'h00;
					ack_to_send = t.ack_after_read;
					eng_step    = S_RD_A;
				end
				OP_CHECK: eng_step = S_CK_A;
				OP_ACK: begin
					ack_to_send = 1'b1;
					eng_step    = S_AK_A;
				end
				default: begin
					ack_to_send = 1'b0;
					eng_step    = S_AK_A;
				end
			endcase
		end
		if (eng_step != S_IDLE) begin
			// Pin writes at the first tick of a step; closing steps finish here.
			if (dly_cnt == 16'd0) begin
				case (eng_step)
					S_ST_A: begin
						sda_q = 1'b1;
						scl_q = 1'b1;
					end
					S_ST_F: begin
						sda_q = 1'b0;
						scl_q = 1'b0;
						fin   = 1'b1;
					end
					S_SP_A: begin
						sda_q = 1'b0;
						scl_q = 1'b1;
					end
					S_SP_F: begin
						sda_q = 1'b1;
						fin   = 1'b1;
					end
					S_WR_A: begin
						if (bit_cnt != 4'd0) begin
							scl_q = 1'b0;
						end
						sda_q = shift_q[7];
					end
					S_WR_B, S_RD_A, S_AK_B, S_CK_B: scl_q = 1'b1;
					S_RD_B, S_AK_C, S_CK_C: scl_q = 1'b0;
					S_WR_F: begin
						scl_q = 1'b0;
						sda_q = 1'b1;
						fin   = 1'b1;
					end
					S_AK_A: sda_q = !ack_to_send;
					S_CK_A: sda_q = 1'b1;
					S_AK_F: begin
						if (ack_to_send) begin
							sda_q = 1'b1;
						end
						if (eng_cmd == OP_READ) begin
							read_byte = shift_q;
						end
						fin = 1'b1;
					end
					default: fin = 1'b1;
				endcase
				if (fin) begin
					r.done   = 1'b1;
					eng_step = S_IDLE;
				end else begin
					dly_cnt = (half_ticks != 16'd0) ? half_ticks : 16'd1;
				end
			end
			// Count down the step; sampling happens on its last tick.
			if (!fin) begin
				dly_cnt = dly_cnt - 16'd1;
				if (dly_cnt == 16'd0) begin
					case (eng_step)
						S_ST_A: eng_step = S_ST_F;
						S_SP_A: eng_step = S_SP_F;
						S_WR_A: eng_step = S_WR_B;
						S_WR_B: begin
							shift_q  = {shift_q[6:0], 1'b0};
							bit_cnt  = bit_cnt + 4'd1;
							eng_step = (bit_cnt >= BITS_PER_BYTE) ? S_WR_F : S_WR_A;
						end
						S_RD_A: begin
							shift_q  = {shift_q[6:0], t.sda_sample};
							eng_step = S_RD_B;
						end
						S_RD_B: begin
							bit_cnt  = bit_cnt + 4'd1;
							eng_step = (bit_cnt >= BITS_PER_BYTE) ? S_AK_A : S_RD_A;
						end
						S_AK_A: eng_step = S_AK_B;
						S_AK_B: eng_step = S_AK_C;
						S_AK_C: eng_step = S_AK_F;
						S_CK_A: eng_step = S_CK_B;
						S_CK_B: begin
							ack_seen = t.sda_sample;
							eng_step = S_CK_C;
						end
						S_CK_C: eng_step = S_CK_F;
						default: eng_step = S_IDLE;
					endcase
				end
			end
		end
		r.scl  = scl_q;
		r.sda  = sda_q;
		r.busy = (eng_step != S_IDLE);
		r.rd   = read_byte;
		r.ack  = ack_seen;
		return r;
	endfunction

	// Later mismatches are counted but not reported to keep the log readable.
	function automatic void flag_field(string where, string field, logic [7:0] want,
		logic [7:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP) begin
			$error("%s: %s expected %0h, got %0h", where, field, want, got);
		end
	endfunction

	function automatic void check_beat(string where, bus_beat_t want, bus_beat_t got);
		if (got.scl !== want.scl) begin
			flag_field(where, "scl_level", 8'(want.scl), 8'(got.scl));
		end
		if (got.sda !== want.sda) begin
			flag_field(where, "sda_level", 8'(want.sda), 8'(got.sda));
		end
		if (got.busy !== want.busy) begin
			flag_field(where, "busy_res", 8'(want.busy), 8'(got.busy));
		end
		if (got.done !== want.done) begin
			flag_field(where, "done_res", 8'(want.done), 8'(got.done));
		end
		if (got.rd !== want.rd) begin
			flag_field(where, "read_data", want.rd, got.rd);
		end
		if (got.ack !== want.ack) begin
			flag_field(where, "ack_status", 8'(want.ack), 8'(got.ack));
		end
	endfunction

	// Accepted tick beats feed the model; accepted result beats are checked.
	always @(posedge clk) begin : monitor
		tick_t     seen;
		bus_beat_t got;
		if (arst_n && tick_if.valid && tick_if.ready) begin
			seen = '{tick_if.command_valid, tick_if.operation, tick_if.write_byte,
				tick_if.ack_after_read, tick_if.sda_sample};
			last_model_beat = advance_engine(seen);
			pending_beats.push_back(last_model_beat);
			ticks_taken++;
		end
		if (arst_n && res_if.valid && res_if.ready) begin
			got = '{res_if.scl_level, res_if.sda_level, res_if.busy_res, res_if.done_res,
				res_if.read_data, res_if.ack_status};
			beats_checked++;
			if (got.done === 1'b1) begin
				done_pulses++;
			end
			if (pending_beats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_CAP) begin
					$error("result beat arrived with nothing expected");
				end
			end else begin
				check_beat("result", pending_beats.pop_front(), got);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// Result sink stalls at random.
	always @(negedge clk) begin
		res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Offer one tick beat, with random gaps first, and wait until it is taken.
	// Called and returns at a falling edge.
	task automatic send_tick(tick_t t);
		while ($urandom_range(99) < src_idle_pct) begin
			tick_if.valid <= 1'b0;
			@(negedge clk);
		end
		tick_if.valid          <= 1'b1;
		tick_if.command_valid  <= t.command_valid;
		tick_if.operation      <= t.operation;
		tick_if.write_byte     <= t.write_byte;
		tick_if.ack_after_read <= t.ack_after_read;
		tick_if.sda_sample     <= t.sda_sample;
		@(posedge clk);
		while (!tick_if.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Run the engine to idle, then hold off until every result has arrived.
	task automatic drain_engine();
		while (eng_step != S_IDLE) begin
			send_tick(idle_tick());
		end
		tick_if.valid <= 1'b0;
		while (pending_beats.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic set_half_period(logic [15:0] value);
		drain_engine();
		cfg_we     <= 1'b1;
		cfg_wdata  <= value;
		half_ticks = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random commands, offered mostly when the engine is idle; a few are offered
	// while it is busy or carry the unused code, and both are dropped.
	task automatic run_random(int n_cmds);
		int    started;
		tick_t t;
		started = 0;
		while (started < n_cmds) begin
			t = idle_tick();
			if (eng_step == S_IDLE) begin
				if ($urandom_range(99) < 75) begin
					t.command_valid = 1'b1;
					if ($urandom_range(99) < 5) begin
						t.operation = OP_UNUSED;
					end else begin
						t.operation = 3'($urandom_range(OP_LAST));
						started++;
					end
				end
			end else if ($urandom_range(99) < 3) begin
				t.command_valid = 1'b1;
			end
			send_tick(t);
		end
	endtask

	// Main sequence.
	initial begin
		tick_t t;
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = 16'd0;
		tick_if.valid          = 1'b0;
		tick_if.command_valid  = 1'b0;
		tick_if.operation      = OP_START;
		tick_if.write_byte     = 8'h00;
		tick_if.ack_after_read = 1'b0;
		tick_if.sda_sample     = 1'b0;
		eng_step               = S_IDLE;
		eng_cmd                = OP_START;
		dly_cnt                = 16'd0;
		bit_cnt                = 4'd0;
		shift_q                = 8'h00;
		ack_seen               = 1'b0;
		ack_to_send            = 1'b0;
		scl_q                  = 1'b1;
		sda_q                  = 1'b1;
		read_byte              = 8'h00;
		half_ticks             = HALF_RESET;
		src_idle_pct           = 21;
		snk_idle_pct           = 71;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed commands; the closing beat is compared where it is typed in.
		for (int i = 0; i < $size(DIR_PLAN); i++) begin
			if (DIR_PLAN[i].set_half) begin
				set_half_period(DIR_PLAN[i].half);
			end
			t                = idle_tick();
			t.command_valid  = DIR_PLAN[i].cmd_valid;
			t.operation      = DIR_PLAN[i].opcode;
			t.write_byte     = DIR_PLAN[i].wbyte;
			t.ack_after_read = DIR_PLAN[i].ackr;
			t.sda_sample     = pick_sda(DIR_PLAN[i].sda_mode);
			send_tick(t);
			if (DIR_PLAN[i].intrude) begin
				t.command_valid = 1'b1;
				t.operation     = OP_START;
				t.sda_sample    = pick_sda(DIR_PLAN[i].sda_mode);
				send_tick(t);
			end
			while (eng_step != S_IDLE) begin
				t            = idle_tick();
				t.sda_sample = pick_sda(DIR_PLAN[i].sda_mode);
				send_tick(t);
			end
			if (DIR_PLAN[i].has_want) begin
				check_beat($sformatf("directed row %0d", i), DIR_PLAN[i].want,
					last_model_beat);
			end
		end

		// Random commands: sender lightly idle and sink mostly stalled.
		set_half_period(16'd3);
		run_random(2);
		set_half_period(16'd1);
		run_random(5);

		// Sender mostly idle, sink lightly stalled.
		src_idle_pct = 71;
		snk_idle_pct = 21;
		set_half_period(16'd0);
		run_random(5);
		set_half_period(16'd2);
		run_random(3);

		// Full rate on both sides.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		set_half_period(16'd1);
		run_random(4);
		set_half_period(16'd2);
		run_random(2);
		drain_engine();
		repeat (8) @(negedge clk);

		$display("Ran %0d bus commands over %0d ticks, half periods 0 through 100.",
			cmds_run, ticks_taken);
		$display("Checked %0d result beats with %0d done pulses; %0d mismatches.",
			beats_checked, done_pulses, mismatch_count);
		if (mismatch_count == 0 && pending_beats.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
